@@ design/opr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package opr_pkg;

   // register offsets
   localparam logic [7:0] OFF_CONTROL = 8'h00;
   localparam logic [7:0] OFF_ENABLE  = 8'h04;
   localparam logic [7:0] OFF_STATUS  = 8'h08;
   localparam logic [7:0] OFF_TIMING  = 8'h0C;
   localparam logic [7:0] OFF_DATA0   = 8'h80;
   localparam logic [7:0] OFF_DATA1   = 8'h84;
   localparam logic [7:0] OFF_DATA2   = 8'h88;
   localparam logic [7:0] OFF_DATA3   = 8'h8C;

   // access sizes
   localparam logic [3:0] SIZE_HALF = 4'd2;
   localparam logic [3:0] SIZE_WORD = 4'd4;

   // error codes
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_BAD_SIZE = 2'd1;
   localparam logic [1:0] ERR_WIDTH    = 2'd2;
   localparam logic [1:0] ERR_NO_REG   = 2'd3;

   // control fields
   localparam logic [15:0] CTRL_MASK    = 16'h39FF;
   localparam int          CMD_WR_BIT   = 15;
   localparam int          CMD_RD_BIT   = 13;
   localparam int          PAGE_FIELD_W = 9;
   localparam int          DONE_BIT     = 0;

   // reset values
   localparam logic [15:0] ENABLE_RESET = 16'hFFFF;
   localparam logic [31:0] TIMING_RESET = 32'h0000_1485;

   localparam int WORDS_PER_PAGE = 4;
   localparam int DATA_W         = 32;

   typedef struct packed {
      logic                    valid;
      logic                    wr;
      logic                    rd;
      logic [PAGE_FIELD_W-1:0] page;
   } eng_cmd_type;

   typedef struct packed {
      logic              en;
      logic [1:0]        idx;
      logic [DATA_W-1:0] data;
   } dw_wr_type;

endpackage

`default_nettype wire

@@ design/opr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module opr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/opr_page_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module opr_page_engine
   import opr_pkg::*;
#(
   parameter int PAGE_COUNT = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire eng_cmd_type       cmd,
   input  wire logic [15:0]       byte_enable,
   input  wire logic [DATA_W-1:0] dw_rdata,
   output logic      [1:0]        dw_idx,
   output dw_wr_type              dw_wr,
   output logic                   busy
);

   localparam int PAGE_BITS   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int DEPTH       = PAGE_COUNT * WORDS_PER_PAGE;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + PAGE_COUNT - 1) / PAGE_COUNT;
   localparam int PROD_W      = PAGE_FIELD_W + RECIP_SHIFT;
   localparam int REM_W       = 2 * PAGE_FIELD_W + 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_RUN   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [ADDR_BITS-1:0]    clr_ff, clr_in;
   logic                    wr_ff, wr_in;
   logic                    rd_ff, rd_in;
   logic [PAGE_FIELD_W-1:0] raw_ff, raw_in;
   logic [PAGE_FIELD_W-1:0] quo_ff, quo_in;
   logic [PAGE_BITS-1:0]    page_ff, page_in;
   logic [2:0]              iss_ff, iss_in;
   logic                    pv_ff, pv_in;
   logic [1:0]              pidx_ff, pidx_in;

   logic [PROD_W-1:0]       prod;
   logic [REM_W-1:0]        rem_full;
   logic                    ram_we, ram_re;
   logic [ADDR_BITS-1:0]    ram_waddr, ram_raddr;
   logic [DATA_W-1:0]       ram_wdata, ram_rdata;
   logic [DATA_W-1:0]       mask;
   logic [DATA_W-1:0]       new_page_word;
   logic [3:0]              be_nib;

   opr_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // page mod PAGE_COUNT by reciprocal multiply, quotient registered first
   assign prod     = PROD_W'(raw_ff) * PROD_W'(RECIP);
   assign rem_full = REM_W'(raw_ff) - REM_W'(quo_ff) * REM_W'(PAGE_COUNT);

   assign be_nib = byte_enable[{pidx_ff, 2'b00} +: 4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mask[8*k +: 8] = {8{be_nib[k]}};
      end
      new_page_word = wr_ff ? ((ram_rdata & ~mask) | (dw_rdata & mask)) : ram_rdata;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      raw_in   = raw_ff;
      quo_in   = quo_ff;
      page_in  = page_ff;
      iss_in   = iss_ff;
      pv_in    = 1'b0;
      pidx_in  = pidx_ff;
      ram_re   = 1'b0;
      ram_raddr = {page_ff, iss_ff[1:0]};
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.valid) begin
               wr_in    = cmd.wr;
               rd_in    = cmd.rd;
               raw_in   = cmd.page;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in   = prod[PROD_W-1 -: PAGE_FIELD_W];
            state_in = ST_MOD;
         end
         ST_MOD: begin
            page_in  = rem_full[PAGE_BITS-1:0];
            iss_in   = 3'd0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            // issue one read per cycle, merge and write back in the cycle after
            if (iss_ff != 3'd4) begin
               ram_re  = 1'b1;
               pv_in   = 1'b1;
               pidx_in = iss_ff[1:0];
               iss_in  = iss_ff + 3'd1;
            end
            if (pv_ff && pidx_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = pv_ff && wr_ff;
         ram_waddr = {page_ff, pidx_ff};
         ram_wdata = new_page_word;
      end
      dw_wr.en   = pv_ff && rd_ff;
      dw_wr.idx  = pidx_ff;
      dw_wr.data = (dw_rdata & ~mask) | (new_page_word & mask);
   end

   assign dw_idx = pidx_ff;
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pv_ff    <= 1'b0;
         iss_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pv_ff    <= pv_in;
         iss_ff   <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ff   <= wr_in;
      rd_ff   <= rd_in;
      raw_ff  <= raw_in;
      quo_ff  <= quo_in;
      page_ff <= page_in;
      pidx_ff <= pidx_in;
   end

endmodule

`default_nettype wire

@@ design/otp_page_register_device.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake                Payload
// req      in   req_tvalid / req_tready  tuser: req_type; tdata: offset, size, write data
// rsp      out  rsp_tvalid / rsp_tready  tdata: read_data, access_error
//
// A register access is answered from the output register, where its response
// sits while the next request is taken. A control write with a command bit set
// runs the page engine: ST_DIV and ST_MOD for the page modulo, then ST_RUN for the
// four store words; req_tready stays low until the engine is idle again.
// After reset the store is swept to zero, all PAGE_COUNT*4 words, with req_tready low.
// A stalled response holds req_tready low.

module otp_page_register_device
   import opr_pkg::*;
#(
   parameter int PAGE_COUNT = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // reg_offset[7:0], access_bytes[11:8],
                                         // write_data[43:12], zero pad
   input  wire logic        req_tuser,   // req_type: 0 read, 1 write
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // read_data[31:0], access_error[33:32], zero pad
);

   logic [15:0]       control_ff, control_in;
   logic [15:0]       enable_ff, enable_in;
   logic [15:0]       status_ff, status_in;
   logic [31:0]       timing_ff, timing_in;
   logic [DATA_W-1:0] dw_ff [WORDS_PER_PAGE];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_err_ff, rsp_err_in;

   logic              accept;
   logic              is_wr;
   logic [7:0]        offset;
   logic [3:0]        size;
   logic [31:0]       val;
   logic [1:0]        err;
   logic [3:0]        need;
   logic [31:0]       rd_val;
   logic [1:0]        req_idx;
   logic [1:0]        dw_sel;
   logic [1:0]        eng_idx;
   logic [DATA_W-1:0] dw_rdata;
   logic              eng_busy;
   eng_cmd_type       cmd;
   dw_wr_type         eng_wr;

   assign is_wr   = req_tuser;
   assign offset  = req_tdata[7:0];
   assign size    = req_tdata[11:8];
   assign val     = (size == SIZE_HALF) ? {16'h0000, req_tdata[27:12]} : req_tdata[43:12];
   assign req_idx = offset[3:2];

   assign req_tready = !eng_busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign dw_sel   = eng_busy ? eng_idx : req_idx;
   assign dw_rdata = dw_ff[dw_sel];

   always_comb begin
      need = 4'd0;
      err  = ERR_OK;
      if (size != SIZE_HALF && size != SIZE_WORD) begin
         err = ERR_BAD_SIZE;
      end else begin
         unique case (offset)
            OFF_CONTROL, OFF_ENABLE, OFF_STATUS: need = SIZE_HALF;
            OFF_TIMING, OFF_DATA0, OFF_DATA1, OFF_DATA2, OFF_DATA3: need = SIZE_WORD;
            default: err = ERR_NO_REG;
         endcase
         if (err == ERR_OK && need != size) begin
            err = ERR_WIDTH;
         end
      end
   end

   always_comb begin
      unique case (offset)
         OFF_CONTROL: rd_val = {16'h0000, control_ff};
         OFF_ENABLE:  rd_val = {16'h0000, enable_ff};
         OFF_STATUS:  rd_val = {16'h0000, status_ff};
         OFF_TIMING:  rd_val = timing_ff;
         default:     rd_val = dw_rdata;
      endcase
   end

   always_comb begin
      control_in   = control_ff;
      enable_in    = enable_ff;
      status_in    = status_ff;
      timing_in    = timing_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = err;
         rsp_data_in  = (err == ERR_OK && !is_wr) ? rd_val : 32'h0;
         if (err == ERR_OK && is_wr) begin
            unique case (offset)
               OFF_CONTROL: begin
                  control_in        = val[15:0] & CTRL_MASK;
                  status_in[DONE_BIT] = 1'b1;
                  cmd.wr            = val[CMD_WR_BIT];
                  cmd.rd            = val[CMD_RD_BIT];
                  cmd.page          = val[PAGE_FIELD_W-1:0];
                  cmd.valid         = val[CMD_WR_BIT] | val[CMD_RD_BIT];
               end
               OFF_ENABLE: enable_in = val[15:0];
               OFF_STATUS: status_in = status_ff & ~val[15:0];
               OFF_TIMING: timing_in = val;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= 16'h0000;
         enable_ff    <= ENABLE_RESET;
         status_ff    <= 16'h0000;
         timing_ff    <= TIMING_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WORDS_PER_PAGE; i++) begin
            dw_ff[i] <= '0;
         end
      end else begin
         control_ff   <= control_in;
         enable_ff    <= enable_in;
         status_ff    <= status_in;
         timing_ff    <= timing_in;
         rsp_valid_ff <= rsp_valid_in;
         if (eng_wr.en) begin
            dw_ff[eng_wr.idx] <= eng_wr.data;
         end else if (accept && is_wr && err == ERR_OK && offset[7]) begin
            dw_ff[req_idx] <= val;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   opr_page_engine #(
      .PAGE_COUNT(PAGE_COUNT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .byte_enable(enable_ff),
      .dw_rdata   (dw_rdata),
      .dw_idx     (eng_idx),
      .dw_wr      (eng_wr),
      .busy       (eng_busy)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_err_ff, rsp_data_ff};

endmodule

`default_nettype wire
